// File: sv/twm_pkg.sv
// ----------------------------------------------------------------------------
// twm_pkg
// Shared types and constants of the torque window oscillation monitor.
// ----------------------------------------------------------------------------
package twm_pkg;

   localparam int DRIVE_W     = 3;
   localparam int ACTIVE_W    = 4;
   localparam int TOL_W       = 15;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;
   localparam logic [TOL_W-1:0]    TOL_RESET    = 15'h7FFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACTIVE_DRIVES       = 2'd0,
      CSR_COMMAND_TOLERANCE   = 2'd1,
      CSR_FOLLOWING_TOLERANCE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [ACTIVE_W-1:0] active_drives;
      logic [TOL_W-1:0]    command_tolerance;
      logic [TOL_W-1:0]    following_tolerance;
   } cfg_type;

endpackage

// File: sv/twm_if.sv
// ----------------------------------------------------------------------------
// twm_if
// Request, response and register write channels of the monitor.
// ----------------------------------------------------------------------------
interface twm_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic [twm_pkg::DRIVE_W-1:0]   drive;
   logic signed [SAMPLE_BITS-1:0] command_deviation;
   logic signed [SAMPLE_BITS-1:0] following_error;

   modport source (output valid, output drive, output command_deviation,
                   output following_error, input ready);
   modport sink   (input valid, input drive, input command_deviation,
                   input following_error, output ready);
endinterface

interface twm_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic [twm_pkg::DRIVE_W-1:0]   drive_out;
   logic signed [SAMPLE_BITS-1:0] average_command;
   logic signed [SAMPLE_BITS-1:0] average_following;
   logic                          command_oscillation;
   logic                          following_oscillation;
   logic                          window_full;

   modport source (output valid, output drive_out, output average_command,
                   output average_following, output command_oscillation,
                   output following_oscillation, output window_full,
                   input ready);
   modport sink   (input valid, input drive_out, input average_command,
                   input average_following, input command_oscillation,
                   input following_oscillation, input window_full,
                   output ready);
endinterface

interface twm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [twm_pkg::CSR_INDEX_W-1:0] index;
   logic [twm_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/twm_ram.sv
// ----------------------------------------------------------------------------
// twm_ram
// Single-port-write, single-port-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module twm_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/twm_csr.sv
// ----------------------------------------------------------------------------
// twm_csr
// Configuration registers: active drive count and the two tolerances.
// ----------------------------------------------------------------------------
module twm_csr (
   input  logic            clock,
   input  logic            reset,
   twm_csr_if.sink         csr_if,
   output twm_pkg::cfg_type cfg
);

   twm_pkg::cfg_type cfg_ff;
   logic             wr;

   assign csr_if.ready = 1'b1;
   assign wr           = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_drives       <= twm_pkg::ACTIVE_RESET;
         cfg_ff.command_tolerance   <= twm_pkg::TOL_RESET;
         cfg_ff.following_tolerance <= twm_pkg::TOL_RESET;
      end else if (wr) begin
         unique case (twm_pkg::csr_index_type'(csr_if.index))
            twm_pkg::CSR_ACTIVE_DRIVES: begin
               cfg_ff.active_drives <= csr_if.data[twm_pkg::ACTIVE_W-1:0];
            end
            twm_pkg::CSR_COMMAND_TOLERANCE: begin
               cfg_ff.command_tolerance <= csr_if.data[twm_pkg::TOL_W-1:0];
            end
            twm_pkg::CSR_FOLLOWING_TOLERANCE: begin
               cfg_ff.following_tolerance <= csr_if.data[twm_pkg::TOL_W-1:0];
            end
            default: begin
               // unused index: write dropped
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/torque_window_oscillation_monitor.sv
// ----------------------------------------------------------------------------
// torque_window_oscillation_monitor
// Per-drive moving window of torque command deviation and following error.
// Every request carries one sample pair for one drive; for an active drive
// (index below the active_drives register, capped at MAX_DRIVES) one
// response follows with both window averages (sum >>> log2(WINDOW_LEN),
// also while the window fills), a flag per average strictly above its
// tolerance, and a window_full flag. Requests for inactive drives are taken
// and dropped. Throughput is one request per clock while the response
// side does not stall; the ring and sum RAM reads are registered into
// stage 1, then the sum update into the response register. The sample ring
// (MAX_DRIVES x WINDOW_LEN entries) and the running sums live in two
// synchronous RAMs; back-to-back requests to one drive forward the fresh
// sum, and ring slots never collide since each request advances the slot.
// No clearing pass after reset: sums use per-drive valid bits, and ring
// entries are only read once written. WINDOW_LEN must be a power of two.
// Registers may only be written while no request is in flight.
// ----------------------------------------------------------------------------
module torque_window_oscillation_monitor #(
   parameter int WINDOW_LEN  = 64,
   parameter int MAX_DRIVES  = 8,
   parameter int SAMPLE_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   twm_req_if.sink  req_if,
   twm_rsp_if.source rsp_if,
   twm_csr_if.sink  csr_if
);

   localparam int LOG2W     = $clog2(WINDOW_LEN);
   localparam int SUM_W     = SAMPLE_BITS + LOG2W;
   // drive field is 3 bits wide, so at most 8 drives are addressable
   localparam int DRV_N     = (MAX_DRIVES > 8) ? 8 : MAX_DRIVES;
   localparam int DRV_W     = (DRV_N > 1) ? $clog2(DRV_N) : 1;
   localparam int DRV_SLOTS = 1 << DRV_W;
   localparam int RING_AW   = DRV_W + LOG2W;
   localparam int CMP_W     = (SAMPLE_BITS - 1 > twm_pkg::TOL_W) ?
                              SAMPLE_BITS - 1 : twm_pkg::TOL_W;
   localparam logic [4:0]       MaxDrv   = 5'(MAX_DRIVES);
   localparam logic [LOG2W-1:0] LastSlot = LOG2W'(WINDOW_LEN - 1);

   // ---------------- configuration ----------------
   twm_pkg::cfg_type cfg;

   twm_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   // ---------------- request stage ----------------
   logic                 advance;
   logic                 accept;
   logic                 take;
   logic [4:0]           limit;
   logic [DRV_W-1:0]     req_idx;
   logic [LOG2W-1:0]     cur_ptr;
   logic                 cur_full;
   logic                 new_full;

   // per-drive ring write slot and full flag
   logic [LOG2W-1:0]     ptr_ff  [DRV_SLOTS];
   logic [DRV_SLOTS-1:0] full_ff;
   logic [DRV_SLOTS-1:0] sum_valid_ff;

   // stage 1: RAM read in flight
   logic                          s1_valid_ff;
   logic [twm_pkg::DRIVE_W-1:0]   s1_drive_ff;
   logic [LOG2W-1:0]              s1_ptr_ff;
   logic signed [SAMPLE_BITS-1:0] s1_cmd_ff;
   logic signed [SAMPLE_BITS-1:0] s1_fol_ff;
   logic                          s1_sub_ff;   // window was full: drop oldest
   logic                          s1_full_ff;  // full after this sample
   logic                          s1_fwd_ff;   // take sums from fwd_*_ff
   logic                          s1_sv_ff;    // sum RAM entry written before

   // last sums written, for a back-to-back request to the same drive
   logic signed [SUM_W-1:0]       fwd_cmd_ff;
   logic signed [SUM_W-1:0]       fwd_fol_ff;

   // response register
   logic                          rsp_valid_ff;
   logic [twm_pkg::DRIVE_W-1:0]   rsp_drive_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_avg_cmd_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_avg_fol_ff;
   logic                          rsp_osc_cmd_ff;
   logic                          rsp_osc_fol_ff;
   logic                          rsp_full_ff;

   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign accept  = req_if.valid && advance;
   assign limit   = (5'(cfg.active_drives) > MaxDrv) ? MaxDrv
                                                     : 5'(cfg.active_drives);
   assign take    = accept && (5'(req_if.drive) < limit);
   assign req_idx = req_if.drive[DRV_W-1:0];
   assign cur_ptr = ptr_ff[req_idx];
   assign cur_full = full_ff[req_idx];
   assign new_full = cur_full || (cur_ptr == LastSlot);

   assign req_if.ready = advance;

   // ---------------- memories ----------------
   logic [DRV_W-1:0]         s1_idx;
   logic                     mem_wr;
   logic [2*SAMPLE_BITS-1:0] ring_rd;
   logic [2*SUM_W-1:0]       sum_rd;
   logic signed [SUM_W-1:0]  cmd_sum_new;
   logic signed [SUM_W-1:0]  fol_sum_new;

   assign s1_idx = s1_drive_ff[DRV_W-1:0];
   assign mem_wr = s1_valid_ff && advance;

   twm_ram #(
      .DEPTH (1 << RING_AW),
      .WIDTH (2 * SAMPLE_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr ({s1_idx, s1_ptr_ff}),
      .wr_data ({s1_fol_ff, s1_cmd_ff}),
      .rd_en   (advance),
      .rd_addr ({req_idx, cur_ptr}),
      .rd_data (ring_rd)
   );

   twm_ram #(
      .DEPTH (DRV_SLOTS),
      .WIDTH (2 * SUM_W)
   ) u_sums (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (s1_idx),
      .wr_data ({fol_sum_new, cmd_sum_new}),
      .rd_en   (advance),
      .rd_addr (req_idx),
      .rd_data (sum_rd)
   );

   // ---------------- sum update ----------------
   logic signed [SUM_W-1:0]       cmd_base;
   logic signed [SUM_W-1:0]       fol_base;
   logic signed [SUM_W-1:0]       cmd_old;
   logic signed [SUM_W-1:0]       fol_old;
   logic signed [SAMPLE_BITS-1:0] avg_cmd;
   logic signed [SAMPLE_BITS-1:0] avg_fol;
   logic                          osc_cmd;
   logic                          osc_fol;

   always_comb begin
      priority if (s1_fwd_ff) begin
         cmd_base = fwd_cmd_ff;
         fol_base = fwd_fol_ff;
      end else if (s1_sv_ff) begin
         cmd_base = $signed(sum_rd[SUM_W-1:0]);
         fol_base = $signed(sum_rd[2*SUM_W-1:SUM_W]);
      end else begin
         cmd_base = '0;
         fol_base = '0;
      end
   end

   // oldest sample leaves only once the window is full
   assign cmd_old = s1_sub_ff ? SUM_W'($signed(ring_rd[SAMPLE_BITS-1:0])) : '0;
   assign fol_old = s1_sub_ff ? SUM_W'($signed(ring_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]))
                              : '0;

   assign cmd_sum_new = cmd_base + SUM_W'(s1_cmd_ff) - cmd_old;
   assign fol_sum_new = fol_base + SUM_W'(s1_fol_ff) - fol_old;

   // floor division by WINDOW_LEN = arithmetic shift
   assign avg_cmd = $signed(cmd_sum_new[SUM_W-1:LOG2W]);
   assign avg_fol = $signed(fol_sum_new[SUM_W-1:LOG2W]);

   assign osc_cmd = !avg_cmd[SAMPLE_BITS-1] &&
                    (CMP_W'(avg_cmd[SAMPLE_BITS-2:0]) > CMP_W'(cfg.command_tolerance));
   assign osc_fol = !avg_fol[SAMPLE_BITS-1] &&
                    (CMP_W'(avg_fol[SAMPLE_BITS-2:0]) > CMP_W'(cfg.following_tolerance));

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DRV_SLOTS; i++) begin
            ptr_ff[i] <= '0;
         end
         full_ff      <= '0;
         sum_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            ptr_ff[req_idx]  <= cur_ptr + 1'b1;
            full_ff[req_idx] <= new_full;
         end
         if (mem_wr) begin
            sum_valid_ff[s1_idx] <= 1'b1;
         end
         if (advance) begin
            s1_valid_ff  <= take;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_drive_ff <= req_if.drive;
         s1_ptr_ff   <= cur_ptr;
         s1_cmd_ff   <= req_if.command_deviation;
         s1_fol_ff   <= req_if.following_error;
         s1_sub_ff   <= cur_full;
         s1_full_ff  <= new_full;
         s1_fwd_ff   <= s1_valid_ff && (s1_drive_ff == req_if.drive);
         s1_sv_ff    <= sum_valid_ff[req_idx];

         fwd_cmd_ff  <= cmd_sum_new;
         fwd_fol_ff  <= fol_sum_new;

         rsp_drive_ff   <= s1_drive_ff;
         rsp_avg_cmd_ff <= avg_cmd;
         rsp_avg_fol_ff <= avg_fol;
         rsp_osc_cmd_ff <= osc_cmd;
         rsp_osc_fol_ff <= osc_fol;
         rsp_full_ff    <= s1_full_ff;
      end
   end

   assign rsp_if.valid                 = rsp_valid_ff;
   assign rsp_if.drive_out             = rsp_drive_ff;
   assign rsp_if.average_command       = rsp_avg_cmd_ff;
   assign rsp_if.average_following     = rsp_avg_fol_ff;
   assign rsp_if.command_oscillation   = rsp_osc_cmd_ff;
   assign rsp_if.following_oscillation = rsp_osc_fol_ff;
   assign rsp_if.window_full           = rsp_full_ff;

endmodule

// File: sv/twm_checker.sv
// ----------------------------------------------------------------------------
// twm_checker
// Port-level checks of the torque window oscillation monitor.
// ----------------------------------------------------------------------------
module twm_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_average_command,
   input logic [SAMPLE_BITS-1:0] rsp_average_following,
   input logic                   rsp_command_oscillation,
   input logic                   rsp_following_oscillation
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average_command)
                                  && $stable(rsp_average_following))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // tolerances are non-negative, so a flagged average cannot be negative
   a_osc_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_command_oscillation || !rsp_average_command[SAMPLE_BITS-1])
                 && (!rsp_following_oscillation
                     || !rsp_average_following[SAMPLE_BITS-1]))
      else $error("oscillation flag on negative average");

   // pipeline: a new response needs a request accepted ahead of stage 1 and the response register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without request");

endmodule

bind torque_window_oscillation_monitor twm_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_twm_checker (
   .clock                     (clock),
   .reset                     (reset),
   .req_valid                 (req_if.valid),
   .req_ready                 (req_if.ready),
   .rsp_valid                 (rsp_if.valid),
   .rsp_ready                 (rsp_if.ready),
   .rsp_average_command       (rsp_if.average_command),
   .rsp_average_following     (rsp_if.average_following),
   .rsp_command_oscillation   (rsp_if.command_oscillation),
   .rsp_following_oscillation (rsp_if.following_oscillation)
);

// File: bench/twm_average_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twm_average_checker
// Watches the request, response and register channels of the monitor. Keeps
// its own copy of the per-drive sample windows, sums and settings, predicts
// one response for every request to an active drive, and compares each
// response field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module twm_average_checker #(
   parameter int WINDOW_LEN  = 64,
   parameter int MAX_DRIVES  = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   twm_req_if   req,
   twm_rsp_if   rsp,
   twm_csr_if   csr,
   output int   failures,
   output int   outstanding
);

   localparam int SHIFT = $clog2(WINDOW_LEN);
   localparam int SUM_W = SAMPLE_BITS + SHIFT + 1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SUM_W-1:0]       sum_type;

   typedef struct packed {
      logic [twm_pkg::DRIVE_W-1:0] drive;
      sample_type                  avg_cmd;
      sample_type                  avg_fol;
      logic                        cmd_osc;
      logic                        fol_osc;
      logic                        full;
   } window_result_type;

   twm_pkg::cfg_type  cfg;
   sample_type        cmd_ring [MAX_DRIVES][WINDOW_LEN];
   sample_type        fol_ring [MAX_DRIVES][WINDOW_LEN];
   sum_type           cmd_sum  [MAX_DRIVES];
   sum_type           fol_sum  [MAX_DRIVES];
   int unsigned       fill     [MAX_DRIVES];
   int unsigned       oldest   [MAX_DRIVES];
   window_result_type expected_averages [$];

   // Pushes one sample pair into its drive's window; returns 0 when the
   // drive is inactive, in which case nothing changes.
   function automatic bit advance_window(input logic [twm_pkg::DRIVE_W-1:0] d,
                                         input sample_type cmd,
                                         input sample_type fol,
                                         output window_result_type r);
      int unsigned limit;
      int unsigned slot;
      sample_type  avg_c;
      sample_type  avg_f;
      r     = '0;
      limit = (cfg.active_drives > MAX_DRIVES) ? MAX_DRIVES : cfg.active_drives;
      if (d >= limit)
         return 1'b0;
      if (fill[d] < WINDOW_LEN) begin
         slot       = fill[d];
         cmd_sum[d] = cmd_sum[d] + cmd;
         fol_sum[d] = fol_sum[d] + fol;
         fill[d]    = fill[d] + 1;
      end else begin
         slot       = oldest[d];
         cmd_sum[d] = cmd_sum[d] + cmd - cmd_ring[d][slot];
         fol_sum[d] = fol_sum[d] + fol - fol_ring[d][slot];
         oldest[d]  = (slot + 1) % WINDOW_LEN;
      end
      cmd_ring[d][slot] = cmd;
      fol_ring[d][slot] = fol;
      // floor division by the window length
      avg_c     = sample_type'(cmd_sum[d] >>> SHIFT);
      avg_f     = sample_type'(fol_sum[d] >>> SHIFT);
      r.drive   = d;
      r.avg_cmd = avg_c;
      r.avg_fol = avg_f;
      r.cmd_osc = int'(avg_c) > int'(cfg.command_tolerance);
      r.fol_osc = int'(avg_f) > int'(cfg.following_tolerance);
      r.full    = fill[d] >= WINDOW_LEN;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      window_result_type want;
      window_result_type fresh;
      if (reset) begin
         cfg.active_drives       = twm_pkg::ACTIVE_RESET;
         cfg.command_tolerance   = twm_pkg::TOL_RESET;
         cfg.following_tolerance = twm_pkg::TOL_RESET;
         for (int i = 0; i < MAX_DRIVES; i++) begin
            cmd_sum[i] = '0;
            fol_sum[i] = '0;
            fill[i]    = 0;
            oldest[i]  = 0;
         end
         expected_averages.delete();
         failures = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_averages.size() == 0) begin
               $error("response for drive %0d with no request pending", rsp.drive_out);
               failures++;
            end else begin
               want = expected_averages.pop_front();
               if (rsp.drive_out !== want.drive) begin
                  $error("drive_out: expected %0d, actual %0d", want.drive, rsp.drive_out);
                  failures++;
               end
               if (rsp.average_command !== want.avg_cmd) begin
                  $error("average_command: expected %0d, actual %0d",
                         $signed(want.avg_cmd), $signed(rsp.average_command));
                  failures++;
               end
               if (rsp.average_following !== want.avg_fol) begin
                  $error("average_following: expected %0d, actual %0d",
                         $signed(want.avg_fol), $signed(rsp.average_following));
                  failures++;
               end
               if (rsp.command_oscillation !== want.cmd_osc) begin
                  $error("command_oscillation: expected %0b, actual %0b",
                         want.cmd_osc, rsp.command_oscillation);
                  failures++;
               end
               if (rsp.following_oscillation !== want.fol_osc) begin
                  $error("following_oscillation: expected %0b, actual %0b",
                         want.fol_osc, rsp.following_oscillation);
                  failures++;
               end
               if (rsp.window_full !== want.full) begin
                  $error("window_full: expected %0b, actual %0b", want.full, rsp.window_full);
                  failures++;
               end
            end
         end
         if (req.valid && req.ready) begin
            if (advance_window(req.drive, req.command_deviation, req.following_error, fresh))
               expected_averages = {expected_averages, fresh};
         end
         if (csr.valid && csr.ready) begin
            unique case (twm_pkg::csr_index_type'(csr.index))
               twm_pkg::CSR_ACTIVE_DRIVES:
                  cfg.active_drives = csr.data[twm_pkg::ACTIVE_W-1:0];
               twm_pkg::CSR_COMMAND_TOLERANCE:
                  cfg.command_tolerance = csr.data[twm_pkg::TOL_W-1:0];
               twm_pkg::CSR_FOLLOWING_TOLERANCE:
                  cfg.following_tolerance = csr.data[twm_pkg::TOL_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding = expected_averages.size();
   end

endmodule

// File: bench/torque_window_oscillation_monitor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// torque_window_oscillation_monitor_tb
// Drives torque samples and register writes into the monitor and lets the
// checker predict and compare every response. A short directed part covers
// sample extremes, tolerance edges and the active-drive special cases; then
// random phases with several settings fill and wrap the windows, with
// random idling on both sides and a long response hold-off.
// ----------------------------------------------------------------------------
module torque_window_oscillation_monitor_tb;

   localparam int WINDOW_LEN   = 64;
   localparam int MAX_DRIVES   = 8;
   localparam int SAMPLE_BITS  = 16;
   localparam int DRAIN_CYCLES = 8;    // margin beyond the block latency
   localparam int HOLD_CYCLES  = 300;  // long enough to back the block up
   localparam int IDLE_PERCENT = 8;

   // index with no register behind it
   localparam logic [twm_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic clock;
   logic reset;
   int   failures;
   int   outstanding;

   // calm: no idling on either side while set
   bit   calm;
   // hold-off handshake between stimulus and the response side
   int   holds_wanted;
   int   holds_taken;
   int   hold_left;

   twm_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   twm_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();
   twm_csr_if                              csr_bus ();

   torque_window_oscillation_monitor #(
      .WINDOW_LEN (WINDOW_LEN),
      .MAX_DRIVES (MAX_DRIVES),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_if(csr_bus)
   );

   twm_average_checker #(
      .WINDOW_LEN (WINDOW_LEN),
      .MAX_DRIVES (MAX_DRIVES),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .csr        (csr_bus),
      .failures   (failures),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case the handshake locks up
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Response side: one assignment to ready per clock. A hold-off request
   // from the stimulus drops ready for HOLD_CYCLES, counted here.
   initial begin
      hold_left     = 0;
      holds_taken   = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (holds_taken != holds_wanted) begin
            holds_taken++;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Offer one request, with random idle cycles ahead of it. Entered and
   // left right after a rising clock; returns once the request has been taken.
   task automatic offer(input logic [twm_pkg::DRIVE_W-1:0] d, input sample_type cmd,
                        input sample_type fol);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid             <= 1'b1;
      req_bus.drive             <= d;
      req_bus.command_deviation <= cmd;
      req_bus.following_error   <= fol;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stop requests and wait until the block has nothing in flight.
   task automatic settle();
      req_bus.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Only call while idle; ends at the edge after the accepting one so that a
   // following write never lands in the same time step.
   task automatic write_register(input logic [twm_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [twm_pkg::CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sample around a center with noise, now and then a full-scale extreme.
   function automatic sample_type noisy_sample(input int center);
      int pick;
      int v;
      pick = $urandom_range(15);
      if (pick == 0)
         return SAMPLE_MAX;
      if (pick == 1)
         return SAMPLE_MIN;
      v = center + int'($urandom_range(2000)) - 1000;
      if (v > int'(SAMPLE_MAX))
         v = int'(SAMPLE_MAX);
      if (v < int'(SAMPLE_MIN))
         v = int'(SAMPLE_MIN);
      return sample_type'(v);
   endfunction

   // One random phase: program all three registers (random unused data
   // bits on top), then send count requests to active drives. Requests to
   // inactive drives are mixed in but not counted, unless none is active.
   task automatic run_phase(input int active, input int cmd_tol, input int fol_tol,
                            input int count, input bit biased, input int cmd_center,
                            input int fol_center, input bit quiet, input bit with_hold);
      logic [twm_pkg::CSR_DATA_W-1:0] data;
      logic [twm_pkg::DRIVE_W-1:0]    drv;
      sample_type                     cmd;
      sample_type                     fol;
      int                             eff;
      int                             sent;
      bit                             held;
      settle();
      data = twm_pkg::CSR_DATA_W'($urandom);
      data[twm_pkg::ACTIVE_W-1:0] = twm_pkg::ACTIVE_W'(active);
      write_register(twm_pkg::CSR_ACTIVE_DRIVES, data);
      data = twm_pkg::CSR_DATA_W'($urandom);
      data[twm_pkg::TOL_W-1:0] = twm_pkg::TOL_W'(cmd_tol);
      write_register(twm_pkg::CSR_COMMAND_TOLERANCE, data);
      data = twm_pkg::CSR_DATA_W'($urandom);
      data[twm_pkg::TOL_W-1:0] = twm_pkg::TOL_W'(fol_tol);
      write_register(twm_pkg::CSR_FOLLOWING_TOLERANCE, data);
      eff  = (active > MAX_DRIVES) ? MAX_DRIVES : active;
      sent = 0;
      held = 1'b0;
      calm = quiet;
      while (sent < count) begin
         if (eff > 0 && $urandom_range(9) != 0)
            drv = twm_pkg::DRIVE_W'($urandom_range(eff - 1));
         else
            drv = twm_pkg::DRIVE_W'($urandom_range(MAX_DRIVES - 1));
         if (biased) begin
            cmd = noisy_sample(cmd_center);
            fol = noisy_sample(fol_center);
         end else begin
            cmd = sample_type'($urandom);
            fol = sample_type'($urandom);
         end
         offer(drv, cmd, fol);
         if (eff == 0 || drv < eff)
            sent++;
         // receiver stalls while requests keep coming
         if (with_hold && !held && sent >= count / 3) begin
            held = 1'b1;
            holds_wanted++;
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      reset                     = 1'b1;
      calm                      = 1'b0;
      holds_wanted              = 0;
      req_bus.valid             = 1'b0;
      req_bus.drive             = '0;
      req_bus.command_deviation = '0;
      req_bus.following_error   = '0;
      csr_bus.valid             = 1'b0;
      csr_bus.index             = '0;
      csr_bus.data              = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: reset settings, full-scale samples, both edge drives
      offer(3'd0, SAMPLE_MAX, SAMPLE_MIN);
      offer(3'd7, SAMPLE_MIN, SAMPLE_MAX);
      offer(3'd0, sample_type'(-1), sample_type'(-1));
      offer(3'd7, '0, '0);
      // back to back on one drive
      offer(3'd3, SAMPLE_MAX, SAMPLE_MAX);
      offer(3'd3, SAMPLE_MAX, SAMPLE_MAX);

      // tolerance zero, top data bit set and masked off
      settle();
      write_register(twm_pkg::CSR_COMMAND_TOLERANCE, 16'h8000);
      write_register(twm_pkg::CSR_FOLLOWING_TOLERANCE, 16'h8000);
      offer(3'd3, '0, '0);                           // both averages well above zero
      offer(3'd5, sample_type'(63), sample_type'(64)); // average 0 vs 1: only second flags
      offer(3'd6, SAMPLE_MIN, sample_type'(-64));    // negative averages never flag

      // fewer active drives: higher indices are dropped
      settle();
      write_register(twm_pkg::CSR_ACTIVE_DRIVES, 16'hFFF2);
      offer(3'd2, sample_type'(1000), sample_type'(1000));
      offer(3'd7, sample_type'(1000), sample_type'(1000));
      offer(3'd1, sample_type'(5), sample_type'(5));

      // no active drive at all, then a write to an unmapped index
      settle();
      write_register(twm_pkg::CSR_ACTIVE_DRIVES, 16'hABC0);
      offer(3'd0, sample_type'(7), sample_type'(7));
      settle();
      write_register(CSR_UNMAPPED, 16'h0005);
      offer(3'd0, sample_type'(7), sample_type'(7));

      // count above the drive limit; earlier state of drive 7 reused
      settle();
      write_register(twm_pkg::CSR_ACTIVE_DRIVES, 16'h000F);
      offer(3'd7, sample_type'(100), sample_type'(-100));
      offer(3'd2, sample_type'(1), sample_type'(1));

      // back to reset-like settings, largest tolerance can never be exceeded
      settle();
      write_register(twm_pkg::CSR_ACTIVE_DRIVES, 16'h5558);
      write_register(twm_pkg::CSR_COMMAND_TOLERANCE, 16'h7FFF);
      write_register(twm_pkg::CSR_FOLLOWING_TOLERANCE, 16'hFFFF);
      offer(3'd0, SAMPLE_MAX, SAMPLE_MAX);

      // ---- random phases
      // all drives, full-range samples
      run_phase(8, 32767, 32767, 120, 1'b0, 0, 0, 1'b0, 1'b0);
      // two drives so the windows wrap; tolerances sit at the mean level
      run_phase(2, 300, 150, 130, 1'b1, 300, 150, 1'b0, 1'b1);
      // nothing active: all dropped
      run_phase(0, 0, 0, 16, 1'b0, 0, 0, 1'b0, 1'b0);
      // count above the limit, random tolerances, with a hold-off
      run_phase(12, $urandom_range(32767), $urandom_range(32767), 80, 1'b0, 0, 0,
                1'b0, 1'b1);
      // three drives, negative command level, no idling at all
      run_phase(3, 0, 2000, 150, 1'b1, -500, 2000, 1'b1, 1'b1);

      settle();
      if (failures == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
